>>> sv/mesh_frame_receive_filter_macros.svh
// Assertion macros shared by the mesh frame receive filter checkers.
`ifndef MESH_FRAME_RECEIVE_FILTER_MACROS_SVH
`define MESH_FRAME_RECEIVE_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MFRF_ASSERT_IMP(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("mfrf check failed");

// Next-cycle implication, disabled while reset is low.
`define MFRF_ASSERT_NXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("mfrf check failed");

`endif

>>> sv/mfrf_pkg.sv
// Package: status codes, register indexes and controller/datapath structs.
`timescale 1ns / 1ps
package mfrf_pkg;

  localparam int MAC_W = 48;
  localparam int KEY_W = 56;

  localparam logic [3:0] ST_SHORT       = 4'd0;
  localparam logic [3:0] ST_DUP         = 4'd1;
  localparam logic [3:0] ST_AUDIO_SHORT = 4'd2;
  localparam logic [3:0] ST_AUDIO_BAD   = 4'd3;
  localparam logic [3:0] ST_AUDIO_OK    = 4'd4;
  localparam logic [3:0] ST_COLOR_SHORT = 4'd5;
  localparam logic [3:0] ST_FWD         = 4'd6;
  localparam logic [3:0] ST_COLOR_DONE  = 4'd7;
  localparam logic [3:0] ST_HELLO_SHORT = 4'd8;
  localparam logic [3:0] ST_NEW_NB      = 4'd9;
  localparam logic [3:0] ST_KNOWN       = 4'd10;
  localparam logic [3:0] ST_FULL        = 4'd11;
  localparam logic [3:0] ST_UNKNOWN     = 4'd12;

  localparam logic [7:0] REG_HDR_MIN     = 8'd0;
  localparam logic [7:0] REG_AUDIO_MIN   = 8'd1;
  localparam logic [7:0] REG_COLOR_MIN   = 8'd2;
  localparam logic [7:0] REG_HELLO_MIN   = 8'd3;
  localparam logic [7:0] REG_AUDIO_CODE  = 8'd4;
  localparam logic [7:0] REG_COLOR_CODE  = 8'd5;
  localparam logic [7:0] REG_HELLO_CODE  = 8'd6;
  localparam logic [7:0] REG_MAX_SAMPLES = 8'd7;

  typedef struct packed {
    logic       in_ready;
    logic       load_item;
    logic       hist_start;
    logic       hist_next;
    logic       hist_add;
    logic       nb_start;
    logic       nb_next;
    logic       nb_ins;
    logic       push_fwd;
    logic       push_done;
    logic [3:0] code;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic hdr_short;
    logic hist_empty;
    logic hist_match;
    logic hist_last;
    logic is_audio;
    logic is_color;
    logic is_hello;
    logic audio_short;
    logic color_short;
    logic hello_short;
    logic audio_bad;
    logic nb_empty;
    logic nb_full;
    logic nb_match;
    logic nb_last;
    logic out_space;
  } sts_t;

endpackage

>>> sv/mfrf_in_if.sv
// Input channel: one received frame header per item.
`timescale 1ns / 1ps
interface mfrf_in_if;
  logic        valid;
  logic        ready;
  logic [47:0] sender_mac;
  logic [7:0]  msg_id;
  logic [7:0]  msg_type;
  logic [7:0]  frame_length;
  logic [7:0]  buf_index;
  logic [15:0] sample_count;

  modport source(output valid, sender_mac, msg_id, msg_type, frame_length, buf_index,
                 sample_count, input ready);
  modport sink(input valid, sender_mac, msg_id, msg_type, frame_length, buf_index,
               sample_count, output ready);
endinterface

>>> sv/mfrf_out_if.sv
// Result channel: one filter result per item.
`timescale 1ns / 1ps
interface mfrf_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  status;
  logic [47:0] dest_mac;
  logic [2:0]  slot_written;
  logic [15:0] slot_count;
  logic [4:0]  neighbor_total;
  logic        last;

  modport source(output valid, status, dest_mac, slot_written, slot_count,
                 neighbor_total, last, input ready);
  modport sink(input valid, status, dest_mac, slot_written, slot_count,
               neighbor_total, last, output ready);
endinterface

>>> sv/mfrf_cfg_if.sv
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
interface mfrf_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

>>> sv/mesh_frame_receive_filter.sv
// Top level of the mesh frame receive filter: controller plus datapath.
// Takes one frame header at a time and gives one result item per frame, or for a
// colour frame one forward item per neighbor other than the sender and then a closing
// item with last set. A short frame goes straight to its result; otherwise the history
// lookup walks the stored (sender, id) entries one per cycle through the history RAM
// read port, up to HISTORY_DEPTH entries, and a colour or hello frame then walks the
// stored neighbors through the neighbor RAM, one per cycle (a colour walk waits while
// the output has no room; a hello that is not from a known sender adds an insert step),
// and the result waits for room at the output register.
// One frame is in work at a time; in_ch.ready is high only between frames. Results
// leave through an output register. The history and neighbor tables are cleared at
// reset through fill counts, so no clearing pass is needed. Configuration writes are taken
// at once (cfg_ch.ready is always high) and must happen while the block is idle.
`timescale 1ns / 1ps
module mesh_frame_receive_filter #(
  parameter int NEIGHBOR_SLOTS = 16,
  parameter int HISTORY_DEPTH  = 32,
  parameter int AUDIO_SLOTS    = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  mfrf_in_if.sink    in_ch,
  mfrf_out_if.source out_ch,
  mfrf_cfg_if.sink   cfg_ch
);
  mfrf_pkg::cmd_t cmd;
  mfrf_pkg::sts_t sts;

  // sequencing: lookup, record, dispatch, push
  mfrf_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .sts  (sts),
    .cmd  (cmd)
  );

  // stores, compares and the output register
  mfrf_datapath #(
    .NEIGHBOR_SLOTS(NEIGHBOR_SLOTS),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .AUDIO_SLOTS   (AUDIO_SLOTS)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch),
    .cmd   (cmd),
    .sts   (sts)
  );
endmodule

>>> sv/mfrf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mfrf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

>>> sv/mfrf_ctrl.sv
// Controller: sequences lookup, history update, dispatch and result pushes.
`timescale 1ns / 1ps
module mfrf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  mfrf_pkg::sts_t sts,
  output mfrf_pkg::cmd_t cmd
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_HSCAN = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_NSCAN = 3'd4;
  localparam logic [2:0] S_INS   = 3'd5;
  localparam logic [2:0] S_PUSH  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic [3:0] code_r, code_nxt;
  logic       hello_r, hello_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= mfrf_pkg::ST_SHORT;
      hello_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
      hello_r <= hello_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    hello_nxt = hello_r;
    cmd       = '0;
    cmd.code  = code_r;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.hdr_short) begin
          code_nxt  = mfrf_pkg::ST_SHORT;
          state_nxt = S_PUSH;
        end else if (sts.hist_empty) begin
          state_nxt = S_ADD;
        end else begin
          cmd.hist_start = 1'b1;
          state_nxt      = S_HSCAN;
        end
      end
      S_HSCAN: begin
        if (sts.hist_match) begin
          code_nxt  = mfrf_pkg::ST_DUP;
          state_nxt = S_PUSH;
        end else if (sts.hist_last) begin
          state_nxt = S_ADD;
        end else begin
          cmd.hist_next = 1'b1;
        end
      end
      S_ADD: begin
        cmd.hist_add = 1'b1;
        state_nxt    = S_PUSH;
        if (sts.is_audio) begin
          if (sts.audio_short) code_nxt = mfrf_pkg::ST_AUDIO_SHORT;
          else if (sts.audio_bad) code_nxt = mfrf_pkg::ST_AUDIO_BAD;
          else code_nxt = mfrf_pkg::ST_AUDIO_OK;
        end else if (sts.is_color) begin
          if (sts.color_short) begin
            code_nxt = mfrf_pkg::ST_COLOR_SHORT;
          end else if (sts.nb_empty) begin
            code_nxt = mfrf_pkg::ST_COLOR_DONE;
          end else begin
            cmd.nb_start = 1'b1;
            hello_nxt    = 1'b0;
            state_nxt    = S_NSCAN;
          end
        end else if (sts.is_hello) begin
          if (sts.hello_short) begin
            code_nxt = mfrf_pkg::ST_HELLO_SHORT;
          end else if (sts.nb_empty) begin
            state_nxt = S_INS;
          end else begin
            cmd.nb_start = 1'b1;
            hello_nxt    = 1'b1;
            state_nxt    = S_NSCAN;
          end
        end else begin
          code_nxt = mfrf_pkg::ST_UNKNOWN;
        end
      end
      S_NSCAN: begin
        if (hello_r) begin
          if (sts.nb_match) begin
            code_nxt  = mfrf_pkg::ST_KNOWN;
            state_nxt = S_PUSH;
          end else if (sts.nb_last) begin
            state_nxt = S_INS;
          end else begin
            cmd.nb_next = 1'b1;
          end
        end else if (sts.nb_match || sts.out_space) begin
          // the sender itself is skipped; others wait for room at the output
          cmd.push_fwd = !sts.nb_match;
          if (sts.nb_last) begin
            code_nxt  = mfrf_pkg::ST_COLOR_DONE;
            state_nxt = S_PUSH;
          end else begin
            cmd.nb_next = 1'b1;
          end
        end
      end
      S_INS: begin
        state_nxt = S_PUSH;
        if (sts.nb_full) begin
          code_nxt = mfrf_pkg::ST_FULL;
        end else begin
          cmd.nb_ins = 1'b1;
          code_nxt   = mfrf_pkg::ST_NEW_NB;
        end
      end
      S_PUSH: begin
        if (sts.out_space) begin
          cmd.push_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> sv/mfrf_datapath.sv
// Datapath: config registers, item registers, history/neighbor/slot RAMs, output register.
`timescale 1ns / 1ps
module mfrf_datapath #(
  parameter int NEIGHBOR_SLOTS = 16,
  parameter int HISTORY_DEPTH  = 32,
  parameter int AUDIO_SLOTS    = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  mfrf_in_if.sink        in_ch,
  mfrf_out_if.source     out_ch,
  mfrf_cfg_if.sink       cfg_ch,
  input  mfrf_pkg::cmd_t cmd,
  output mfrf_pkg::sts_t sts
);
  localparam int HAW = HISTORY_DEPTH > 1 ? $clog2(HISTORY_DEPTH) : 1;
  localparam int HFW = $clog2(HISTORY_DEPTH + 1);
  localparam int HSW = HFW + 1;
  localparam int NAW = NEIGHBOR_SLOTS > 1 ? $clog2(NEIGHBOR_SLOTS) : 1;
  localparam int NFW = $clog2(NEIGHBOR_SLOTS + 1);
  localparam int AAW = AUDIO_SLOTS > 1 ? $clog2(AUDIO_SLOTS) : 1;

  // configuration
  logic [7:0]  hdr_min_r, audio_min_r, color_min_r, hello_min_r;
  logic [7:0]  audio_code_r, color_code_r, hello_code_r;
  logic [15:0] max_samples_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_min_r     <= 8'd8;
      audio_min_r   <= 8'd14;
      color_min_r   <= 8'd13;
      hello_min_r   <= 8'd8;
      audio_code_r  <= 8'd1;
      color_code_r  <= 8'd2;
      hello_code_r  <= 8'd3;
      max_samples_r <= 16'd256;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        mfrf_pkg::REG_HDR_MIN:     hdr_min_r     <= cfg_ch.data[7:0];
        mfrf_pkg::REG_AUDIO_MIN:   audio_min_r   <= cfg_ch.data[7:0];
        mfrf_pkg::REG_COLOR_MIN:   color_min_r   <= cfg_ch.data[7:0];
        mfrf_pkg::REG_HELLO_MIN:   hello_min_r   <= cfg_ch.data[7:0];
        mfrf_pkg::REG_AUDIO_CODE:  audio_code_r  <= cfg_ch.data[7:0];
        mfrf_pkg::REG_COLOR_CODE:  color_code_r  <= cfg_ch.data[7:0];
        mfrf_pkg::REG_HELLO_CODE:  hello_code_r  <= cfg_ch.data[7:0];
        mfrf_pkg::REG_MAX_SAMPLES: max_samples_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // captured item
  logic [47:0] mac_r;
  logic [7:0]  id_r, type_r, len_r, idx_r;
  logic [15:0] cnt_r;

  assign in_ch.ready = cmd.in_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      mac_r  <= in_ch.sender_mac;
      id_r   <= in_ch.msg_id;
      type_r <= in_ch.msg_type;
      len_r  <= in_ch.frame_length;
      idx_r  <= in_ch.buf_index;
      cnt_r  <= in_ch.sample_count;
    end
  end

  logic [mfrf_pkg::KEY_W-1:0] key;
  assign key = {mac_r, id_r};

  // history FIFO
  logic [HFW-1:0] hfill_r, hcnt_r;
  logic [HAW-1:0] holdest_r, hptr_r, hptr_inc, holdest_inc, hrd_addr, hwr_addr;
  logic [HSW-1:0] hsum, hwrap;
  logic [mfrf_pkg::KEY_W-1:0] hrd_data;

  assign hptr_inc    = (hptr_r == HAW'(HISTORY_DEPTH - 1)) ? '0 : hptr_r + 1'b1;
  assign holdest_inc = (holdest_r == HAW'(HISTORY_DEPTH - 1)) ? '0 : holdest_r + 1'b1;
  assign hrd_addr    = cmd.hist_start ? holdest_r : hptr_inc;
  // oldest + fill wraps to oldest itself when the FIFO is full
  assign hsum        = HSW'(holdest_r) + HSW'(hfill_r);
  assign hwrap       = (hsum >= HSW'(HISTORY_DEPTH)) ? hsum - HSW'(HISTORY_DEPTH) : hsum;
  assign hwr_addr    = hwrap[HAW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hfill_r   <= '0;
      holdest_r <= '0;
    end else if (cmd.hist_add) begin
      if (hfill_r != HFW'(HISTORY_DEPTH)) hfill_r <= hfill_r + 1'b1;
      else holdest_r <= holdest_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_start) begin
      hptr_r <= holdest_r;
      hcnt_r <= '0;
    end else if (cmd.hist_next) begin
      hptr_r <= hptr_inc;
      hcnt_r <= hcnt_r + 1'b1;
    end
  end

  mfrf_ram #(.WIDTH(mfrf_pkg::KEY_W), .DEPTH(HISTORY_DEPTH)) u_hist_ram (
    .clk    (clk),
    .wr_en  (cmd.hist_add),
    .wr_addr(hwr_addr),
    .wr_data(key),
    .rd_en  (cmd.hist_start | cmd.hist_next),
    .rd_addr(hrd_addr),
    .rd_data(hrd_data)
  );

  // neighbor table
  logic [NFW-1:0] nfill_r;
  logic [NAW-1:0] ncnt_r, nrd_addr;
  logic [mfrf_pkg::MAC_W-1:0] nrd_data;

  assign nrd_addr = cmd.nb_start ? '0 : ncnt_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nfill_r <= '0;
    end else if (cmd.nb_ins) begin
      nfill_r <= nfill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.nb_start) ncnt_r <= '0;
    else if (cmd.nb_next) ncnt_r <= ncnt_r + 1'b1;
  end

  mfrf_ram #(.WIDTH(mfrf_pkg::MAC_W), .DEPTH(NEIGHBOR_SLOTS)) u_nb_ram (
    .clk    (clk),
    .wr_en  (cmd.nb_ins),
    .wr_addr(nfill_r[NAW-1:0]),
    .wr_data(mac_r),
    .rd_en  (cmd.nb_start | cmd.nb_next),
    .rd_addr(nrd_addr),
    .rd_data(nrd_data)
  );

  // audio ready slots
  logic audio_store;
  assign audio_store = cmd.push_done && (cmd.code == mfrf_pkg::ST_AUDIO_OK);

  mfrf_ram #(.WIDTH(16), .DEPTH(AUDIO_SLOTS)) u_slot_ram (
    .clk    (clk),
    .wr_en  (audio_store),
    .wr_addr(idx_r[AAW-1:0]),
    .wr_data(cnt_r),
    .rd_en  (1'b0),
    .rd_addr(idx_r[AAW-1:0]),
    .rd_data()
  );

  // output register
  logic out_valid_r;
  assign out_ch.valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push_fwd || cmd.push_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_fwd || cmd.push_done) begin
      out_ch.status         <= cmd.push_fwd ? mfrf_pkg::ST_FWD : cmd.code;
      out_ch.dest_mac       <= cmd.push_fwd ? nrd_data : '0;
      out_ch.slot_written   <= audio_store ? idx_r[2:0] : 3'd0;
      out_ch.slot_count     <= audio_store ? cnt_r : 16'd0;
      out_ch.neighbor_total <= 5'(nfill_r);
      out_ch.last           <= cmd.push_done;
    end
  end

  // status to the controller
  always_comb begin
    sts             = '0;
    sts.in_valid    = in_ch.valid;
    sts.hdr_short   = len_r < hdr_min_r;
    sts.hist_empty  = hfill_r == '0;
    sts.hist_match  = hrd_data == key;
    sts.hist_last   = hcnt_r == (hfill_r - HFW'(1));
    sts.is_audio    = type_r == audio_code_r;
    sts.is_color    = type_r == color_code_r;
    sts.is_hello    = type_r == hello_code_r;
    sts.audio_short = len_r < audio_min_r;
    sts.color_short = len_r < color_min_r;
    sts.hello_short = len_r < hello_min_r;
    sts.audio_bad   = ({1'b0, idx_r} >= 9'(AUDIO_SLOTS)) || (cnt_r == 16'd0) ||
                      (cnt_r > max_samples_r);
    sts.nb_empty    = nfill_r == '0;
    sts.nb_full     = nfill_r == NFW'(NEIGHBOR_SLOTS);
    sts.nb_match    = nrd_data == mac_r;
    sts.nb_last     = NFW'(ncnt_r) == (nfill_r - NFW'(1));
    sts.out_space   = !out_valid_r || out_ch.ready;
  end
endmodule

>>> sv/mfrf_checker.sv
// Port-level checker for the mesh frame receive filter, bound to the top level.
`timescale 1ns / 1ps
`include "mesh_frame_receive_filter_macros.svh"
module mfrf_props (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_status,
  input logic       out_last
);
  // one frame at a time: no new item right after one is taken
`MFRF_ASSERT_NXT(a_one_frame, clk, rst_n, in_valid && in_ready, !in_ready)
`MFRF_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
`MFRF_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_status <= mfrf_pkg::ST_UNKNOWN)
  // forwards never close a frame, every other status does
`MFRF_ASSERT_IMP(a_fwd_last, clk, rst_n, out_valid, (out_status == mfrf_pkg::ST_FWD) != out_last)
endmodule

bind mesh_frame_receive_filter mfrf_props u_mfrf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_status(out_ch.status),
  .out_last  (out_ch.last)
);
